// ===== sv/lcr_pkg.sv =====
package lcr_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int STACK_CAP  = MAX_WIDTH + 1;

  localparam int WID_W  = 7;   // row width register, heights, positions
  localparam int COL_W  = 6;   // column address into height memories
  localparam int AREA_W = 13;
  localparam int PROD_W = 2 * WID_W;
  localparam int ADDR_W = 3;

  localparam logic [AREA_W-1:0] AREA_CAP = {AREA_W{1'b1}};

  localparam logic [ADDR_W-1:0] REG_ROW_WIDTH = 3'd0;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RDH  = 3'd1;
  localparam logic [2:0] S_FEED = 3'd2;
  localparam logic [2:0] S_POP  = 3'd3;
  localparam logic [2:0] S_POPW = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  typedef struct packed {
    logic             valid;
    logic             clear;
    logic [WID_W-1:0] height;
    logic [WID_W-1:0] span;
  } area_req_t;

endpackage

// ===== sv/lcr_best.sv =====
// Shared area unit: registered multiply, then saturate and keep the maximum.
module lcr_best (
  input  logic                       clk,
  input  logic                       rst,
  input  lcr_pkg::area_req_t         req,
  output logic [lcr_pkg::AREA_W-1:0] best
);

  logic [lcr_pkg::PROD_W-1:0] prod;
  logic                       prod_valid;
  logic [lcr_pkg::AREA_W-1:0] prod_cap;

  assign prod_cap = (prod > lcr_pkg::PROD_W'(lcr_pkg::AREA_CAP)) ? lcr_pkg::AREA_CAP
                                                                : prod[lcr_pkg::AREA_W-1:0];

  always_ff @(posedge clk) begin
    prod <= req.height * req.span;
    if (rst || req.clear) begin
      prod_valid <= 1'b0;
      best       <= '0;
    end else begin
      prod_valid <= req.valid;
      if (prod_valid && prod_cap > best) begin
        best <= prod_cap;
      end
    end
  end

endmodule

// ===== sv/largest_checkerboard_rectangle_core.sv =====
// Channel  Signals                              Direction  Accepted when
// in       in_valid in_stall cell_bit           input      in_valid && !in_stall
//          end_of_board
// out      out_valid out_stall max_area         output     out_valid && !out_stall
//          height_saturated
// cfg      psel penable pwrite paddr pwdata     APB        psel && penable && pwrite
//
// A cell passes through S_RDH, one S_FEED per feed and S_POP/S_POPW for every stack pop,
// then S_DONE; a cell that ends a row runs two extra feeds (the zero height). Pops are
// bounded by pushes. The pop loop is set by the registered read of the stack memory,
// and every area goes through one multiplier.
// rst is synchronous and clears control, heights (valid bits), best area and flag.
// in_stall is high while a cell is in work; a result waiting on out_stall holds
// only the cell that ends the board.
module largest_checkerboard_rectangle_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic                        cell_bit,
  input  logic                        end_of_board,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [lcr_pkg::AREA_W-1:0]  max_area,
  output logic                        height_saturated,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcr_pkg::ADDR_W-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  localparam int W = lcr_pkg::WID_W;
  localparam int C = lcr_pkg::COL_W;

  logic [W-1:0] row_width;
  logic [2:0]   state;
  logic [C-1:0] column_index;
  logic         row_parity;
  logic         sat_flag;

  // latched item
  logic         cell_val;
  logic         eob;
  logic         last;
  logic [C-1:0] col;

  logic [W-1:0] ha_mem [0:lcr_pkg::MAX_WIDTH-1];
  logic [W-1:0] hb_mem [0:lcr_pkg::MAX_WIDTH-1];
  logic [lcr_pkg::MAX_WIDTH-1:0] hv;
  logic [W-1:0] ha_rd, hb_rd;
  logic         hv_rd;
  logic [W-1:0] ha, hb;

  logic [2*W-1:0] stk_mem [0:2**(W+1)-1];
  logic [2*W-1:0] stk_rd;
  logic           stk_we;
  logic [W:0]     stk_waddr, stk_raddr;
  logic [2*W-1:0] stk_wdata;

  logic [W-1:0] depth [0:1];
  logic [W-1:0] top_h [0:1];
  logic [W-1:0] top_s [0:1];
  logic [1:0]   fi;
  logic [W-1:0] start;

  logic         ph;
  logic [W-1:0] fh, fpos, d, th, ts, col_p1, rd_h, rd_s, w_eff;
  logic         push, popgo, pop_more, feed_end, in_acc, emit;
  logic [W-1:0] ha_old, hb_old, ha_new, hb_new;
  logic         ma, sat_a, sat_b;

  lcr_pkg::area_req_t       areq;
  logic [lcr_pkg::AREA_W-1:0] best;

  lcr_best u_best (
    .clk  (clk),
    .rst  (rst),
    .req  (areq),
    .best (best)
  );

  assign pready   = 1'b1;
  assign prdata   = (paddr == lcr_pkg::REG_ROW_WIDTH) ? {{(32-W){1'b0}}, row_width} : 32'd0;
  assign in_stall = (state != lcr_pkg::S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign emit     = !out_valid || !out_stall;

  assign w_eff  = (row_width == '0) ? W'(1) :
                  (row_width > W'(lcr_pkg::MAX_WIDTH)) ? W'(lcr_pkg::MAX_WIDTH) : row_width;
  assign col_p1 = {1'b0, col} + W'(1);

  // height update
  assign ha_old = hv_rd ? ha_rd : '0;
  assign hb_old = hv_rd ? hb_rd : '0;
  assign ma     = (cell_val == (row_parity ^ col[0]));
  assign sat_a  = ma && (ha_old >= W'(lcr_pkg::MAX_HEIGHT));
  assign sat_b  = !ma && (hb_old >= W'(lcr_pkg::MAX_HEIGHT));
  assign ha_new = !ma ? '0 : (sat_a ? W'(lcr_pkg::MAX_HEIGHT) : ha_old + W'(1));
  assign hb_new = ma ? '0 : (sat_b ? W'(lcr_pkg::MAX_HEIGHT) : hb_old + W'(1));

  // feed selection: fi[0] picks the phase, fi[1] marks the row-end zero feed
  assign ph   = fi[0];
  assign fh   = fi[1] ? '0 : (ph ? hb : ha);
  assign fpos = fi[1] ? col_p1 : {1'b0, col};
  assign d    = depth[ph];
  assign th   = top_h[ph];
  assign ts   = top_s[ph];
  assign rd_h = stk_rd[2*W-1:W];
  assign rd_s = stk_rd[W-1:0];

  assign push     = (d == '0) || (th < fh);
  assign popgo    = (d != '0) && (th > fh);
  assign pop_more = (d != '0) && (rd_h >= fh);
  assign feed_end = (fi == 2'd3) || (fi == 2'd1 && !last);

  always_comb begin
    stk_we    = 1'b0;
    stk_wdata = {fh, start};
    stk_waddr = {ph, d};
    stk_raddr = {ph, d - W'(2)};
    if (state == lcr_pkg::S_FEED && push && d < W'(lcr_pkg::STACK_CAP)) begin
      stk_we    = 1'b1;
      stk_wdata = {fh, fpos};
    end else if (state == lcr_pkg::S_POPW && !pop_more) begin
      stk_we    = 1'b1;
    end
    areq.valid  = (state == lcr_pkg::S_POP);
    // best area restarts once the board's result is latched into max_area
    areq.clear  = (state == lcr_pkg::S_DONE) && eob && emit;
    areq.height = th;
    areq.span   = fpos - ts;
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk_mem[stk_waddr] <= stk_wdata;
    end
    stk_rd <= stk_mem[stk_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == lcr_pkg::S_RDH) begin
      ha_mem[col] <= ha_new;
      hb_mem[col] <= hb_new;
    end
    ha_rd <= ha_mem[column_index];
    hb_rd <= hb_mem[column_index];
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      cell_val <= cell_bit;
      eob      <= end_of_board;
      col      <= column_index;
      last     <= ({1'b0, column_index} + W'(1) >= w_eff) || end_of_board;
      hv_rd    <= hv[column_index];
    end
    if (rst) begin
      row_width    <= W'(lcr_pkg::MAX_WIDTH);
      state        <= lcr_pkg::S_IDLE;
      column_index <= '0;
      row_parity   <= 1'b0;
      sat_flag     <= 1'b0;
      hv           <= '0;
      depth[0]     <= '0;
      depth[1]     <= '0;
      fi           <= '0;
      out_valid    <= 1'b0;
    end else begin
      if (psel && penable && pwrite && paddr == lcr_pkg::REG_ROW_WIDTH) begin
        row_width <= pwdata[W-1:0];
      end
      if (out_valid && !out_stall && !(state == lcr_pkg::S_DONE && eob)) begin
        out_valid <= 1'b0;
      end
      case (state)
        lcr_pkg::S_IDLE: begin
          if (in_acc) begin
            state <= lcr_pkg::S_RDH;
          end
        end
        lcr_pkg::S_RDH: begin
          ha      <= ha_new;
          hb      <= hb_new;
          hv[col] <= 1'b1;
          if (sat_a || sat_b) begin
            sat_flag <= 1'b1;
          end
          fi    <= '0;
          state <= lcr_pkg::S_FEED;
        end
        lcr_pkg::S_FEED: begin
          if (popgo) begin
            state <= lcr_pkg::S_POP;
          end else begin
            if (push && d < W'(lcr_pkg::STACK_CAP)) begin
              top_h[ph] <= fh;
              top_s[ph] <= fpos;
              depth[ph] <= d + W'(1);
            end
            fi    <= fi + 2'd1;
            state <= feed_end ? lcr_pkg::S_DONE : lcr_pkg::S_FEED;
          end
        end
        lcr_pkg::S_POP: begin
          start     <= ts;
          depth[ph] <= d - W'(1);
          state     <= lcr_pkg::S_POPW;
        end
        lcr_pkg::S_POPW: begin
          if (pop_more) begin
            top_h[ph] <= rd_h;
            top_s[ph] <= rd_s;
            state     <= lcr_pkg::S_POP;
          end else begin
            top_h[ph] <= fh;
            top_s[ph] <= start;
            depth[ph] <= d + W'(1);
            fi        <= fi + 2'd1;
            state     <= feed_end ? lcr_pkg::S_DONE : lcr_pkg::S_FEED;
          end
        end
        lcr_pkg::S_DONE: begin
          if (!eob || emit) begin
            if (last) begin
              depth[0]     <= '0;
              depth[1]     <= '0;
              column_index <= '0;
              row_parity   <= eob ? 1'b0 : ~row_parity;
            end else begin
              column_index <= col_p1[C-1:0];
            end
            if (eob) begin
              out_valid        <= 1'b1;
              max_area         <= best;
              height_saturated <= sat_flag;
              sat_flag         <= 1'b0;
              hv               <= '0;
            end
            state <= lcr_pkg::S_IDLE;
          end
        end
        default: state <= lcr_pkg::S_IDLE;
      endcase
    end
  end

endmodule
